FILE: rtl/gmm_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the grid maze mapper and navigator.
// No dependencies; used by every other file of the block except gmm_dist_mem.
package gmm_pkg;

  typedef enum logic [2:0] {
    OP_SENSE  = 3'd0,
    OP_MOVE   = 3'd1,
    OP_ROTATE = 3'd2,
    OP_WRITE  = 3'd3,
    OP_QUERY  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  localparam logic [1:0] DIR_LEFT_OFS  = 2'd3;
  localparam logic [1:0] DIR_RIGHT_OFS = 2'd1;
  localparam logic [1:0] DIR_BACK_OFS  = 2'd2;

  localparam int unsigned MAX_COST_BITS  = 10;
  localparam int unsigned MAX_COST_RESET = 255;
  localparam int unsigned WALL_BITS      = 4;
  localparam int unsigned PORT_XY_BITS   = 4;
  localparam int unsigned DV_BITS        = 10;

  typedef struct packed {
    logic in_grid;
    logic less;
  } step_flags_t;

endpackage

FILE: rtl/gmm_step_unit.sv
`timescale 1ns / 1ps
// Shared neighbour stepper and cost comparator of the sequencer.
// Depends on gmm_pkg for direction codes and the flag struct.
module gmm_step_unit #(
  parameter int GRID_SIZE = 16,
  parameter int COST_BITS = 10,
  parameter int CW        = $clog2(GRID_SIZE),
  parameter int LW        = ((COST_BITS > 10) ? COST_BITS : 10) + 1
) (
  input  logic [CW-1:0]        x_i,
  input  logic [CW-1:0]        y_i,
  input  logic [1:0]           dir_i,
  input  logic [COST_BITS-1:0] cost_i,
  input  logic [LW-1:0]        lowest_i,
  output logic [CW-1:0]        nx_o,
  output logic [CW-1:0]        ny_o,
  output gmm_pkg::step_flags_t flags_o
);

  localparam logic [CW-1:0] MAX_C = CW'(GRID_SIZE - 1);

  always_comb begin
    nx_o            = x_i;
    ny_o            = y_i;
    flags_o.in_grid = 1'b1;
    case (dir_i)
      gmm_pkg::DIR_NORTH: begin
        if (y_i == MAX_C) flags_o.in_grid = 1'b0;
        else ny_o = y_i + CW'(1);
      end
      gmm_pkg::DIR_EAST: begin
        if (x_i == MAX_C) flags_o.in_grid = 1'b0;
        else nx_o = x_i + CW'(1);
      end
      gmm_pkg::DIR_SOUTH: begin
        if (y_i == '0) flags_o.in_grid = 1'b0;
        else ny_o = y_i - CW'(1);
      end
      default: begin
        if (x_i == '0) flags_o.in_grid = 1'b0;
        else nx_o = x_i - CW'(1);
      end
    endcase
    flags_o.less = (LW'(cost_i) < lowest_i);
  end

endmodule

FILE: rtl/gmm_wall_mem.sv
`timescale 1ns / 1ps
// Wall map store, one grid row per entry, with a valid flag per row.
// A row never written since reset or clear reads as all zero. Uses gmm_pkg.
module gmm_wall_mem #(
  parameter int GRID_SIZE = 16,
  parameter int CW        = $clog2(GRID_SIZE),
  parameter int RW        = GRID_SIZE * gmm_pkg::WALL_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          rd_en_i,
  input  logic [CW-1:0] rd_row_i,
  output logic [RW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [CW-1:0] wr_row_i,
  input  logic [RW-1:0] wr_data_i
);

  logic [RW-1:0]        mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_vld_q;
  logic [RW-1:0]        rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_row_i];
      end
      if (clr_i) begin
        row_vld_q <= '0;
      end else if (wr_en_i) begin
        row_vld_q[wr_row_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: rtl/gmm_dist_mem.sv
`timescale 1ns / 1ps
// Cost table, one entry per cell, single write and single registered read.
// Contents are undefined until written. Standalone.
module gmm_dist_mem #(
  parameter int GRID_SIZE = 16,
  parameter int COST_BITS = 10,
  parameter int AW        = $clog2(GRID_SIZE * GRID_SIZE)
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [COST_BITS-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [COST_BITS-1:0] wr_data_i
);

  logic [COST_BITS-1:0] mem [GRID_SIZE * GRID_SIZE];
  logic [COST_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/grid_maze_mapper_navigator_top.sv
`timescale 1ns / 1ps
// Grid maze mapper and navigator: sequencer, robot state, result register.
// From request accept to result valid: move, rotate, write, clear and unknown codes pass the
// execute state alone; query does one wall read, one scan step per side, one cost read per open
// side; sense does one read-modify-write of the wall store per cell touched.
// A new request is taken no sooner than the cycle after the result is loaded, so requests never
// overlap; a held result stalls the load. Reset: map reads cleared at once, robot at 0,0 north.
module grid_maze_mapper_navigator_top #(
  parameter int GRID_SIZE = 16,
  parameter int COST_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [9:0]           cfg_max_cost_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           op_i,
  input  logic                 wall_front_i,
  input  logic                 wall_left_i,
  input  logic                 wall_right_i,
  input  logic [1:0]           target_dir_i,
  input  logic [3:0]           cell_x_i,
  input  logic [3:0]           cell_y_i,
  input  logic [9:0]           distance_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           pos_x_o,
  output logic [3:0]           pos_y_o,
  output logic [1:0]           heading_o,
  output logic [1:0]           turn_code_o,
  output logic                 move_blocked_o,
  output logic                 best_found_o,
  output logic [3:0]           best_x_o,
  output logic [3:0]           best_y_o,
  output logic [1:0]           best_dir_o
);

  localparam int CW = $clog2(GRID_SIZE);
  localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int RW = GRID_SIZE * gmm_pkg::WALL_BITS;
  localparam int LW = ((COST_BITS > 10) ? COST_BITS : 10) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RD, S_WR, S_SCAN, S_QHERE, S_QSCAN, S_QCMP, S_DONE
  } state_e;

  state_e               state_q;
  gmm_pkg::op_e         op_q;
  logic                 wall_f_q, wall_l_q, wall_r_q;
  logic [1:0]           target_q;
  logic [3:0]           cx_q, cy_q;
  logic [9:0]           dv_q;
  logic [9:0]           max_cost_q;
  logic [CW-1:0]        robot_x_q, robot_y_q;
  logic [1:0]           heading_q;
  logic [3:0]           walls_q;
  logic [1:0]           dir_q;
  logic [CW-1:0]        tgt_x_q, tgt_y_q;
  logic [3:0]           mask_q;
  logic [3:0]           here_q;
  logic [LW-1:0]        lowest_q;
  logic [1:0]           turn_q;
  logic                 blocked_q, found_q;
  logic [CW-1:0]        bx_q, by_q;
  logic [1:0]           bd_q;
  logic [CW-1:0]        cand_x_q, cand_y_q;

  logic                 out_valid_q;
  logic [3:0]           out_x_q, out_y_q, out_bx_q, out_by_q;
  logic [1:0]           out_hd_q, out_turn_q, out_bd_q;
  logic                 out_blk_q, out_found_q;

  logic [CW-1:0]        step_nx, step_ny;
  logic [1:0]           step_dir;
  gmm_pkg::step_flags_t step_flags;
  logic [COST_BITS-1:0] dist_rd_data;
  logic [RW-1:0]        wall_rd_data;
  logic [RW-1:0]        row_mod;
  logic [3:0]           here_nib;
  logic [3:0]           sense_walls;
  logic                 cell_in_grid;

  logic                 wall_rd_en, wall_wr_en, wall_clr;
  logic [CW-1:0]        wall_rd_row;
  logic                 dist_rd_en, dist_wr_en;
  logic [AW-1:0]        dist_rd_addr, dist_wr_addr;

  assign step_dir = (state_q == S_EXEC) ? heading_q : dir_q;

  gmm_step_unit #(
    .GRID_SIZE(GRID_SIZE),
    .COST_BITS(COST_BITS),
    .CW       (CW),
    .LW       (LW)
  ) u_step (
    .x_i     (robot_x_q),
    .y_i     (robot_y_q),
    .dir_i   (step_dir),
    .cost_i  (dist_rd_data),
    .lowest_i(lowest_q),
    .nx_o    (step_nx),
    .ny_o    (step_ny),
    .flags_o (step_flags)
  );

  always_comb begin
    row_mod  = wall_rd_data;
    here_nib = '0;
    for (int i = 0; i < GRID_SIZE; i++) begin
      if (CW'(i) == tgt_x_q) begin
        row_mod[i*4 +: 4] = wall_rd_data[i*4 +: 4] | mask_q;
      end
      if (CW'(i) == robot_x_q) begin
        here_nib = wall_rd_data[i*4 +: 4];
      end
    end
  end

  always_comb begin
    sense_walls = '0;
    if (wall_f_q) sense_walls[heading_q] = 1'b1;
    if (wall_l_q) sense_walls[2'(heading_q + gmm_pkg::DIR_LEFT_OFS)] = 1'b1;
    if (wall_r_q) sense_walls[2'(heading_q + gmm_pkg::DIR_RIGHT_OFS)] = 1'b1;
  end

  assign cell_in_grid = (int'(cx_q) < GRID_SIZE) && (int'(cy_q) < GRID_SIZE);

  assign wall_rd_en  = (state_q == S_RD) ||
                       ((state_q == S_EXEC) && (op_q == gmm_pkg::OP_QUERY));
  assign wall_rd_row = (state_q == S_RD) ? tgt_y_q : robot_y_q;
  assign wall_wr_en  = (state_q == S_WR);
  assign wall_clr    = (state_q == S_EXEC) && (op_q == gmm_pkg::OP_CLEAR);

  assign dist_wr_en   = (state_q == S_EXEC) && (op_q == gmm_pkg::OP_WRITE) && cell_in_grid;
  assign dist_wr_addr = AW'(AW'(CW'(cy_q)) * AW'(GRID_SIZE) + AW'(CW'(cx_q)));
  assign dist_rd_en   = (state_q == S_QSCAN) && step_flags.in_grid && !here_q[dir_q];
  assign dist_rd_addr = AW'(AW'(step_ny) * AW'(GRID_SIZE) + AW'(step_nx));

  gmm_wall_mem #(
    .GRID_SIZE(GRID_SIZE),
    .CW       (CW),
    .RW       (RW)
  ) u_wall_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (wall_clr),
    .rd_en_i  (wall_rd_en),
    .rd_row_i (wall_rd_row),
    .rd_data_o(wall_rd_data),
    .wr_en_i  (wall_wr_en),
    .wr_row_i (tgt_y_q),
    .wr_data_i(row_mod)
  );

  gmm_dist_mem #(
    .GRID_SIZE(GRID_SIZE),
    .COST_BITS(COST_BITS),
    .AW       (AW)
  ) u_dist_mem (
    .clk_i    (clk_i),
    .rd_en_i  (dist_rd_en),
    .rd_addr_i(dist_rd_addr),
    .rd_data_o(dist_rd_data),
    .wr_en_i  (dist_wr_en),
    .wr_addr_i(dist_wr_addr),
    .wr_data_i(COST_BITS'(dv_q))
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= gmm_pkg::OP_SENSE;
      wall_f_q    <= 1'b0;
      wall_l_q    <= 1'b0;
      wall_r_q    <= 1'b0;
      target_q    <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      dv_q        <= '0;
      max_cost_q  <= 10'(gmm_pkg::MAX_COST_RESET);
      robot_x_q   <= '0;
      robot_y_q   <= '0;
      heading_q   <= gmm_pkg::DIR_NORTH;
      walls_q     <= '0;
      dir_q       <= gmm_pkg::DIR_NORTH;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      mask_q      <= '0;
      here_q      <= '0;
      lowest_q    <= '0;
      turn_q      <= '0;
      blocked_q   <= 1'b0;
      found_q     <= 1'b0;
      bx_q        <= '0;
      by_q        <= '0;
      bd_q        <= '0;
      cand_x_q    <= '0;
      cand_y_q    <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_hd_q    <= '0;
      out_turn_q  <= '0;
      out_blk_q   <= 1'b0;
      out_found_q <= 1'b0;
      out_bx_q    <= '0;
      out_by_q    <= '0;
      out_bd_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_cost_q <= cfg_max_cost_i;
      end
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q      <= gmm_pkg::op_e'(op_i);
            wall_f_q  <= wall_front_i;
            wall_l_q  <= wall_left_i;
            wall_r_q  <= wall_right_i;
            target_q  <= target_dir_i;
            cx_q      <= cell_x_i;
            cy_q      <= cell_y_i;
            dv_q      <= distance_value_i;
            turn_q    <= '0;
            blocked_q <= 1'b0;
            found_q   <= 1'b0;
            bx_q      <= '0;
            by_q      <= '0;
            bd_q      <= '0;
            state_q   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_DONE;
          case (op_q)
            gmm_pkg::OP_SENSE: begin
              walls_q <= sense_walls;
              mask_q  <= sense_walls;
              tgt_x_q <= robot_x_q;
              tgt_y_q <= robot_y_q;
              dir_q   <= gmm_pkg::DIR_NORTH;
              if (sense_walls != '0) state_q <= S_RD;
            end
            gmm_pkg::OP_MOVE: begin
              if (step_flags.in_grid) begin
                robot_x_q <= step_nx;
                robot_y_q <= step_ny;
              end else begin
                blocked_q <= 1'b1;
              end
            end
            gmm_pkg::OP_ROTATE: begin
              turn_q    <= 2'(target_q - heading_q);
              heading_q <= target_q;
            end
            gmm_pkg::OP_QUERY: begin
              lowest_q <= LW'(max_cost_q) + LW'(1);
              dir_q    <= gmm_pkg::DIR_NORTH;
              state_q  <= S_QHERE;
            end
            gmm_pkg::OP_CLEAR: begin
              robot_x_q <= '0;
              robot_y_q <= '0;
              heading_q <= gmm_pkg::DIR_NORTH;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_RD: begin
          state_q <= S_WR;
        end
        S_WR: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (walls_q == '0) begin
            state_q <= S_DONE;
          end else begin
            walls_q[dir_q] <= 1'b0;
            dir_q          <= dir_q + 2'd1;
            if (walls_q[dir_q] && step_flags.in_grid) begin
              tgt_x_q <= step_nx;
              tgt_y_q <= step_ny;
              mask_q  <= 4'b0001 << 2'(dir_q + gmm_pkg::DIR_BACK_OFS);
              state_q <= S_RD;
            end
          end
        end
        S_QHERE: begin
          here_q  <= here_nib;
          state_q <= S_QSCAN;
        end
        S_QSCAN: begin
          if (step_flags.in_grid && !here_q[dir_q]) begin
            cand_x_q <= step_nx;
            cand_y_q <= step_ny;
            state_q  <= S_QCMP;
          end else if (dir_q == gmm_pkg::DIR_WEST) begin
            state_q <= S_DONE;
          end else begin
            dir_q <= dir_q + 2'd1;
          end
        end
        S_QCMP: begin
          if (step_flags.less) begin
            lowest_q <= LW'(dist_rd_data);
            found_q  <= 1'b1;
            bx_q     <= cand_x_q;
            by_q     <= cand_y_q;
            bd_q     <= dir_q;
          end
          if (dir_q == gmm_pkg::DIR_WEST) begin
            state_q <= S_DONE;
          end else begin
            dir_q   <= dir_q + 2'd1;
            state_q <= S_QSCAN;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= 4'(robot_x_q);
            out_y_q     <= 4'(robot_y_q);
            out_hd_q    <= heading_q;
            out_turn_q  <= turn_q;
            out_blk_q   <= blocked_q;
            out_found_q <= found_q;
            out_bx_q    <= 4'(bx_q);
            out_by_q    <= 4'(by_q);
            out_bd_q    <= bd_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = out_x_q;
  assign pos_y_o        = out_y_q;
  assign heading_o      = out_hd_q;
  assign turn_code_o    = out_turn_q;
  assign move_blocked_o = out_blk_q;
  assign best_found_o   = out_found_q;
  assign best_x_o       = out_bx_q;
  assign best_y_o       = out_by_q;
  assign best_dir_o     = out_bd_q;

endmodule

FILE: rtl/gmm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the grid maze mapper and navigator, with its bind.
// Depends on gmm_pkg and grid_maze_mapper_navigator_top.
module gmm_checker #(
  parameter int GRID_SIZE = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] pos_x_o,
  input logic [3:0] pos_y_o,
  input logic [1:0] heading_o,
  input logic [1:0] turn_code_o,
  input logic       move_blocked_o,
  input logic       best_found_o,
  input logic [3:0] best_x_o,
  input logic [3:0] best_y_o,
  input logic [1:0] best_dir_o
);

  localparam logic [3:0] EDGE = 4'(GRID_SIZE - 1);

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while a previous one is in progress");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) &&
    $stable(pos_y_o) && $stable(heading_o) && $stable(best_found_o))
    else $error("stalled result changed");

  a_no_best_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !best_found_o |-> best_x_o == '0 && best_y_o == '0 &&
    best_dir_o == '0)
    else $error("neighbour fields set without a choice");

  a_turn_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && turn_code_o != '0 |-> !move_blocked_o && !best_found_o)
    else $error("turn reported together with move or query flags");

  a_blocked_at_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_blocked_o |->
      (heading_o == gmm_pkg::DIR_NORTH && pos_y_o == EDGE) ||
      (heading_o == gmm_pkg::DIR_EAST && pos_x_o == EDGE) ||
      (heading_o == gmm_pkg::DIR_SOUTH && pos_y_o == '0) ||
      (heading_o == gmm_pkg::DIR_WEST && pos_x_o == '0))
    else $error("move blocked away from the grid edge");

endmodule

bind grid_maze_mapper_navigator_top gmm_checker #(.GRID_SIZE(GRID_SIZE)) u_gmm_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_maze_mapper_navigator_top: bursty requests, a stalling result
// sink and an in-order check against a predictor of the wall map, cost table and robot state.
// Depends on rtl/gmm_pkg.sv and rtl/grid_maze_mapper_navigator_top.sv.
module tb;

  localparam int GRID = 16;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 217;
  localparam int SINK_FREE = 0;
  localparam int SINK_HALF = 1;
  localparam int SINK_SLOW = 2;

  typedef struct {
    bit         is_cfg;
    logic [9:0] cfg_value;
    logic [2:0] op;
    logic       wall_front;
    logic       wall_left;
    logic       wall_right;
    logic [1:0] target_dir;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [9:0] distance_value;
  } nav_request_t;

  typedef struct {
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [1:0] heading;
    logic [1:0] turn_code;
    logic       move_blocked;
    logic       best_found;
    logic [3:0] best_x;
    logic [3:0] best_y;
    logic [1:0] best_dir;
  } nav_outcome_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [9:0] cfg_max_cost_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] op_i = '0;
  logic       wall_front_i = 1'b0;
  logic       wall_left_i = 1'b0;
  logic       wall_right_i = 1'b0;
  logic [1:0] target_dir_i = '0;
  logic [3:0] cell_x_i = '0;
  logic [3:0] cell_y_i = '0;
  logic [9:0] distance_value_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] pos_x_o;
  logic [3:0] pos_y_o;
  logic [1:0] heading_o;
  logic [1:0] turn_code_o;
  logic       move_blocked_o;
  logic       best_found_o;
  logic [3:0] best_x_o;
  logic [3:0] best_y_o;
  logic [1:0] best_dir_o;

  nav_request_t pending_requests[$];
  nav_outcome_t expected_outcomes[$];
  int outstanding = 0;
  int mismatches = 0;
  int requests_done = 0;
  int cfg_writes = 0;
  int queries_found = 0;
  int moves_blocked = 0;

  // predictor state
  logic [3:0] walls [GRID*GRID] = '{default: 4'h0};
  logic [9:0] costs [GRID*GRID];
  logic [3:0] at_x = '0;
  logic [3:0] at_y = '0;
  logic [1:0] facing = gmm_pkg::DIR_NORTH;
  logic [9:0] cost_limit = 10'(gmm_pkg::MAX_COST_RESET);

  grid_maze_mapper_navigator_top #(
    .GRID_SIZE(GRID),
    .COST_BITS(gmm_pkg::MAX_COST_BITS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_max_cost_i  (cfg_max_cost_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .wall_front_i    (wall_front_i),
    .wall_left_i     (wall_left_i),
    .wall_right_i    (wall_right_i),
    .target_dir_i    (target_dir_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .distance_value_i(distance_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .heading_o       (heading_o),
    .turn_code_o     (turn_code_o),
    .move_blocked_o  (move_blocked_o),
    .best_found_o    (best_found_o),
    .best_x_o        (best_x_o),
    .best_y_o        (best_y_o),
    .best_dir_o      (best_dir_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic bit neighbour(input logic [3:0] x, input logic [3:0] y,
                                   input logic [1:0] d, output logic [3:0] nx,
                                   output logic [3:0] ny);
    nx = x;
    ny = y;
    case (d)
      gmm_pkg::DIR_NORTH: begin
        if (y == GRID - 1) return 1'b0;
        ny = y + 4'd1;
      end
      gmm_pkg::DIR_EAST: begin
        if (x == GRID - 1) return 1'b0;
        nx = x + 4'd1;
      end
      gmm_pkg::DIR_SOUTH: begin
        if (y == 0) return 1'b0;
        ny = y - 4'd1;
      end
      default: begin
        if (x == 0) return 1'b0;
        nx = x - 4'd1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void mark_wall(input logic [1:0] d);
    logic [3:0] nx;
    logic [3:0] ny;
    logic [1:0] back;
    back = d + gmm_pkg::DIR_BACK_OFS;
    walls[{at_y, at_x}][d] = 1'b1;
    if (neighbour(at_x, at_y, d, nx, ny)) walls[{ny, nx}][back] = 1'b1;
  endfunction

  function automatic nav_outcome_t navigate(input nav_request_t rq);
    nav_outcome_t res;
    logic [3:0] nx;
    logic [3:0] ny;
    int unsigned lowest;
    res = '{default: '0};
    case (rq.op)
      gmm_pkg::OP_SENSE: begin
        if (rq.wall_front) mark_wall(facing);
        if (rq.wall_left) mark_wall(facing + gmm_pkg::DIR_LEFT_OFS);
        if (rq.wall_right) mark_wall(facing + gmm_pkg::DIR_RIGHT_OFS);
      end
      gmm_pkg::OP_MOVE: begin
        if (neighbour(at_x, at_y, facing, nx, ny)) begin
          at_x = nx;
          at_y = ny;
        end else begin
          res.move_blocked = 1'b1;
        end
      end
      gmm_pkg::OP_ROTATE: begin
        res.turn_code = rq.target_dir - facing;
        facing = rq.target_dir;
      end
      gmm_pkg::OP_WRITE: begin
        costs[{rq.cell_y, rq.cell_x}] = rq.distance_value;
      end
      gmm_pkg::OP_QUERY: begin
        lowest = cost_limit + 1;
        for (int d = 0; d < 4; d++) begin
          if (neighbour(at_x, at_y, d[1:0], nx, ny) && !walls[{at_y, at_x}][d] &&
              costs[{ny, nx}] < lowest) begin
            lowest = 32'(costs[{ny, nx}]);
            res.best_found = 1'b1;
            res.best_x = nx;
            res.best_y = ny;
            res.best_dir = d[1:0];
          end
        end
      end
      gmm_pkg::OP_CLEAR: begin
        foreach (walls[i]) walls[i] = '0;
        at_x = '0;
        at_y = '0;
        facing = gmm_pkg::DIR_NORTH;
      end
      default: ;
    endcase
    res.pos_x = at_x;
    res.pos_y = at_y;
    res.heading = facing;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [9:0] draw_cost();
    case ($urandom_range(0, 3))
      0: return 10'($urandom_range(0, 3));
      3: return 10'($urandom_range(0, 1023));
      default: return 10'($urandom_range(0, 400));
    endcase
  endfunction

  task automatic push_op(input logic [2:0] op, input logic front, input logic left,
                         input logic right, input logic [1:0] tdir, input logic [3:0] cx,
                         input logic [3:0] cy, input logic [9:0] dv);
    nav_request_t rq;
    rq = '{is_cfg: 1'b0, cfg_value: '0, op: op, wall_front: front, wall_left: left,
           wall_right: right, target_dir: tdir, cell_x: cx, cell_y: cy, distance_value: dv};
    pending_requests.push_back(rq);
  endtask

  task automatic push_cfg(input logic [9:0] value);
    nav_request_t rq;
    rq = '{default: '0};
    rq.is_cfg = 1'b1;
    rq.cfg_value = value;
    pending_requests.push_back(rq);
  endtask

  // driver: bursts of requests with random gaps; cost limit writes only once drained
  int burst_left = 12;
  int gap_left = 0;
  int quiet_cycles = 0;

  always @(posedge clk_i or negedge rst_ni) begin : driver
    nav_request_t rq;
    logic next_in_valid;
    logic next_cfg_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      next_in_valid = in_valid_i && !in_ready_o;
      next_cfg_valid = cfg_valid_i && !cfg_ready_o;
      if (!next_in_valid && !next_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          if (pending_requests[0].is_cfg) begin
            if (outstanding == 0) quiet_cycles++;
            else quiet_cycles = 0;
            if (quiet_cycles >= SETTLE_CYCLES) begin
              rq = pending_requests.pop_front();
              cfg_max_cost_i <= rq.cfg_value;
              next_cfg_valid = 1'b1;
              quiet_cycles = 0;
            end
          end else begin
            rq = pending_requests.pop_front();
            op_i <= rq.op;
            wall_front_i <= rq.wall_front;
            wall_left_i <= rq.wall_left;
            wall_right_i <= rq.wall_right;
            target_dir_i <= rq.target_dir;
            cell_x_i <= rq.cell_x;
            cell_y_i <= rq.cell_y;
            distance_value_i <= rq.distance_value;
            next_in_valid = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 48);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
          end
        end
      end
      in_valid_i <= next_in_valid;
      cfg_valid_i <= next_cfg_valid;
    end
  end

  // result sink: own stall pattern plus one long hold-off
  int taken = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int sink_mode = SINK_FREE;
  int mode_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) taken++;
      if (!hold_done && taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode = $urandom_range(SINK_FREE, SINK_SLOW);
          mode_left = $urandom_range(5, 80);
        end
        mode_left--;
        case (sink_mode)
          SINK_FREE: out_ready_i <= 1'b1;
          SINK_HALF: out_ready_i <= 1'($urandom_range(0, 1));
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    nav_request_t rq;
    nav_outcome_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cost_limit = cfg_max_cost_i;
        cfg_writes++;
      end
      if (in_valid_i && in_ready_o) begin
        rq = '{is_cfg: 1'b0, cfg_value: '0, op: op_i, wall_front: wall_front_i,
               wall_left: wall_left_i, wall_right: wall_right_i, target_dir: target_dir_i,
               cell_x: cell_x_i, cell_y: cell_y_i, distance_value: distance_value_i};
        want = navigate(rq);
        if (want.best_found) queries_found++;
        if (want.move_blocked) moves_blocked++;
        requests_done++;
        expected_outcomes.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no request waiting");
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("pos_x", want.pos_x, pos_x_o);
          check_field("pos_y", want.pos_y, pos_y_o);
          check_field("heading", want.heading, heading_o);
          check_field("turn_code", want.turn_code, turn_code_o);
          check_field("move_blocked", want.move_blocked, move_blocked_o);
          check_field("best_found", want.best_found, best_found_o);
          check_field("best_x", want.best_x, best_x_o);
          check_field("best_y", want.best_y, best_y_o);
          check_field("best_dir", want.best_dir, best_dir_o);
        end
      end
      outstanding <= expected_outcomes.size();
    end
  end

  initial begin : stimulus
    logic [2:0] op;
    logic [9:0] limit;
    int pick;

    // tie on the two open neighbours of the corner, then wall them off
    push_op(gmm_pkg::OP_WRITE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd1, 10'd10);
    push_op(gmm_pkg::OP_WRITE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd1, 4'd0, 10'd10);
    push_op(gmm_pkg::OP_QUERY, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_SENSE, 1'b1, 1'b1, 1'b1, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_QUERY, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);
    // every turn, and moves blocked at both grid edges
    push_op(gmm_pkg::OP_ROTATE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_SOUTH, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_MOVE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_ROTATE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_WEST, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_MOVE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_ROTATE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_WEST, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_ROTATE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_ROTATE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_WEST, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_ROTATE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_EAST, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_MOVE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);
    // neighbours above the limit, one behind a mirrored wall
    push_op(gmm_pkg::OP_WRITE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd1, 4'd1, 10'd1023);
    push_op(gmm_pkg::OP_WRITE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd2, 4'd0, 10'd300);
    push_op(gmm_pkg::OP_WRITE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_QUERY, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);
    push_op(gmm_pkg::OP_SENSE, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_WEST, 4'd15, 4'd15, 10'd1023);
    push_op(OP_SPARE_LO, 1'b1, 1'b1, 1'b1, gmm_pkg::DIR_WEST, 4'd15, 4'd15, 10'd1023);
    push_op(OP_SPARE_HI, 1'b1, 1'b1, 1'b1, gmm_pkg::DIR_EAST, 4'd15, 4'd0, 10'd512);
    push_op(gmm_pkg::OP_WRITE, 1'b1, 1'b1, 1'b1, gmm_pkg::DIR_WEST, 4'd15, 4'd15, 10'd1023);
    push_op(gmm_pkg::OP_CLEAR, 1'b1, 1'b1, 1'b1, gmm_pkg::DIR_WEST, 4'd15, 4'd15, 10'd1023);
    push_op(gmm_pkg::OP_QUERY, 1'b0, 1'b0, 1'b0, gmm_pkg::DIR_NORTH, 4'd0, 4'd0, 10'd0);

    // load the whole cost table so later queries never read an empty entry
    for (int idx = 0; idx < GRID * GRID; idx++)
      push_op(gmm_pkg::OP_WRITE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), idx[3:0], idx[7:4],
              draw_cost());

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: limit = 10'd0;
        1: limit = 10'd1022;
        2: limit = 10'd511;
        3: limit = 10'($urandom_range(1, 1021));
        4: limit = 10'd64;
        default: limit = 10'd300;
      endcase
      push_cfg(limit);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) op = gmm_pkg::OP_SENSE;
        else if (pick < 40) op = gmm_pkg::OP_MOVE;
        else if (pick < 52) op = gmm_pkg::OP_ROTATE;
        else if (pick < 67) op = gmm_pkg::OP_WRITE;
        else if (pick < 92) op = gmm_pkg::OP_QUERY;
        else if (pick < 95) op = gmm_pkg::OP_CLEAR;
        else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        push_op(op, $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                $urandom_range(0, 2) == 0, 2'($urandom_range(0, 3)),
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), draw_cost());
      end
    end

    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || cfg_valid_i || outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_outcomes.size() != 0) begin
      $error("%0d results never arrived", expected_outcomes.size());
      mismatches += expected_outcomes.size();
    end
    $display("Ran %0d requests over %0d cost limit writes and a long sink hold-off;",
             requests_done, cfg_writes);
    $display("%0d queries picked a neighbour, %0d moves stopped at the grid edge.",
             queries_found, moves_blocked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: grid_maze_mapper_navigator_top.f
rtl/gmm_pkg.sv
rtl/gmm_step_unit.sv
rtl/gmm_wall_mem.sv
rtl/gmm_dist_mem.sv
rtl/grid_maze_mapper_navigator_top.sv
rtl/gmm_checker.sv
tb/tb.sv
